// File: design/pxmc_pkg.sv
// ----------------------------------------------------------------------------
// pxmc_pkg
// Shared types and constants of the x-monotone chain splitter: controller
// states, command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pxmc_pkg;

	localparam int unsigned PXMC_MAX_SEGMENTS = 64;
	localparam int unsigned PXMC_COORD_BITS   = 32;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_SEGMENT  = 2'd0,
		STATUS_NO_PARTS = 2'd1,
		STATUS_ARC      = 2'd2,
		STATUS_OVERFLOW = 2'd3
	} status_t;

	// direction of one segment along x
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FALL = 2'd1,
		DIR_RISE = 2'd2
	} dir_t;

	// controller states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_WALK_END,
		ST_EMIT_CHK,
		ST_PT_RD,
		ST_PT_EV,
		ST_SEG_RD,
		ST_SEG_EV,
		ST_ONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic clr;
		logic walk_init;
		logic walk_rd;
		logic walk_ev;
		logic walk_flush;
		logic emit_init;
		logic pt_rd;
		logic pt_ev;
		logic next_part;
		logic seg_rd;
		logic seg_ev;
		logic res_one;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic err_any;
		logic p_last;
		logic parts_zero;
		logic kind_match;
		logic i_last;
		logic parts_done;
		logic slot_free;
	} stat_t;

endpackage

`default_nettype wire

// File: design/pxmc_ram.sv
// ----------------------------------------------------------------------------
// pxmc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pxmc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/pxmc_ctrl.sv
// ----------------------------------------------------------------------------
// pxmc_ctrl
// Controller of the chain splitter: loads an outline, walks the loop to
// build the part table, then sequences the emission passes or the single status result.
// ----------------------------------------------------------------------------
`default_nettype none

module pxmc_ctrl
	import pxmc_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   s_tvalid,
	input  wire   s_tlast,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (s_tlast) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.err_any) begin
					state_d = ST_ONE;
				end else begin
					cmd.walk_init = 1'b1;
					state_d = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				cmd.walk_rd = 1'b1;
				state_d = ST_WALK_EV;
			end
			ST_WALK_EV: begin
				cmd.walk_ev = 1'b1;
				state_d = stat.p_last ? ST_WALK_END : ST_WALK_RD;
			end
			ST_WALK_END: begin
				cmd.walk_flush = 1'b1;
				state_d = ST_EMIT_CHK;
			end
			ST_EMIT_CHK: begin
				if (stat.parts_zero) begin
					state_d = ST_ONE;
				end else begin
					cmd.emit_init = 1'b1;
					state_d = ST_PT_RD;
				end
			end
			ST_PT_RD: begin
				cmd.pt_rd = 1'b1;
				state_d = ST_PT_EV;
			end
			ST_PT_EV: begin
				if (stat.kind_match) begin
					cmd.pt_ev = 1'b1;
					state_d = ST_SEG_RD;
				end else begin
					cmd.next_part = 1'b1;
					if (stat.parts_done) begin
						cmd.clr = 1'b1;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_PT_RD;
					end
				end
			end
			ST_SEG_RD: begin
				cmd.seg_rd = 1'b1;
				state_d = ST_SEG_EV;
			end
			ST_SEG_EV: begin
				if (stat.slot_free) begin
					cmd.seg_ev = 1'b1;
					if (stat.i_last) begin
						cmd.next_part = 1'b1;
						if (stat.parts_done) begin
							cmd.clr = 1'b1;
							state_d = ST_LOAD;
						end else begin
							state_d = ST_PT_RD;
						end
					end else begin
						state_d = ST_SEG_RD;
					end
				end
			end
			ST_ONE: begin
				if (stat.slot_free) begin
					cmd.res_one = 1'b1;
					cmd.clr = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule

`default_nettype wire

// File: design/pxmc_dp.sv
// ----------------------------------------------------------------------------
// pxmc_dp
// Datapath of the chain splitter: segment store, part table, walk and
// emission counters, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pxmc_dp
	import pxmc_pkg::*;
#(
	parameter int unsigned MAX_SEGMENTS = PXMC_MAX_SEGMENTS,
	parameter int unsigned COORD_BITS   = PXMC_COORD_BITS
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire          cfg_wdata,
	input  wire [127:0]  s_tdata,
	input  wire          s_tuser,
	input  cmd_t         cmd,
	output stat_t        stat,
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [127:0] m_tdata,
	output logic [3:0]   m_tuser,
	output logic         m_tlast
);

	localparam int unsigned AW  = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW  = AW + 1;
	localparam int unsigned CB  = COORD_BITS;
	localparam int unsigned SW  = 4 * CB;
	localparam int unsigned PTW = AW + CW + 1;

	// outline state
	logic                 hole_q;
	logic [CW-1:0]        count_q;
	logic signed [CB-1:0] least_q;
	logic [AW-1:0]        start_q;
	logic [1:0]           err_q;

	// walk state
	logic [AW-1:0] p_q;
	dir_t          dir_q;
	logic [AW-1:0] off_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] parts_q;
	logic [1:0]    has_q;
	logic [AW-1:0] lastk0_q, lastk1_q;

	// emission state
	logic          pass_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] po_q;
	logic [CW-1:0] pl_q;
	logic          kind_q;
	logic [CW-1:0] i_q;

	// memories
	logic          seg_we, seg_re, pt_we, pt_re;
	logic [AW-1:0] seg_waddr, seg_raddr, pt_waddr;
	logic [SW-1:0] seg_wdata, seg_rdata;
	logic [PTW-1:0] pt_wdata, pt_rdata;
	logic [AW-1:0] pt_raddr_w;

	// input coordinates, low bits only
	logic signed [CB-1:0] in_sx, in_sy, in_ex, in_ey;
	assign in_sx = s_tdata[CB-1:0];
	assign in_sy = s_tdata[32+CB-1:32];
	assign in_ex = s_tdata[64+CB-1:64];
	assign in_ey = s_tdata[96+CB-1:96];

	logic room;
	assign room = count_q < CW'(MAX_SEGMENTS);

	assign seg_we    = cmd.load && room;
	assign seg_waddr = count_q[AW-1:0];
	assign seg_wdata = {in_ey, in_ex, in_sy, in_sx};

	// stored segment fields
	logic signed [CB-1:0] r_sx, r_sy, r_ex, r_ey;
	assign r_sx = seg_rdata[CB-1:0];
	assign r_sy = seg_rdata[2*CB-1:CB];
	assign r_ex = seg_rdata[3*CB-1:2*CB];
	assign r_ey = seg_rdata[4*CB-1:3*CB];

	dir_t seg_dir;
	always_comb begin
		if (r_sx > r_ex)      seg_dir = DIR_FALL;
		else if (r_ex > r_sx) seg_dir = DIR_RISE;
		else                  seg_dir = DIR_NONE;
	end

	// read address: walk offset from the start segment, wrapped round
	logic          rev;
	logic [CW-1:0] rel_idx, sum_idx, wrap_idx;
	assign rev = kind_q == hole_q;
	always_comb begin
		if (cmd.seg_rd) begin
			rel_idx = rev ? CW'({1'b0, po_q} + pl_q - CW'(1) - i_q)
			              : CW'({1'b0, po_q} + i_q);
		end else begin
			rel_idx = {1'b0, p_q};
		end
		sum_idx  = CW'({1'b0, start_q} + rel_idx);
		wrap_idx = (sum_idx >= count_q) ? CW'(sum_idx - count_q) : sum_idx;
	end
	assign seg_re    = cmd.walk_rd || cmd.seg_rd;
	assign seg_raddr = wrap_idx[AW-1:0];

	// closing a run writes one part table entry
	logic run_cont, part_kind_w;
	assign run_cont    = (seg_dir != DIR_NONE) && (seg_dir == dir_q);
	assign pt_we       = ((cmd.walk_ev && !run_cont) || cmd.walk_flush) && (dir_q != DIR_NONE);
	assign part_kind_w = (dir_q == DIR_FALL) ? hole_q : !hole_q;
	assign pt_waddr    = parts_q[AW-1:0];
	assign pt_wdata    = {part_kind_w, len_q, off_q};
	assign pt_re       = cmd.pt_rd;
	assign pt_raddr_w  = k_q;

	pxmc_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
		.clk   (clk),
		.we    (seg_we),
		.waddr (seg_waddr),
		.wdata (seg_wdata),
		.re    (seg_re),
		.raddr (seg_raddr),
		.rdata (seg_rdata)
	);

	pxmc_ram #(.WIDTH(PTW), .DEPTH(MAX_SEGMENTS)) u_part_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.re    (pt_re),
		.raddr (pt_raddr_w),
		.rdata (pt_rdata)
	);

	// status towards the controller
	logic          k_last, i_last, final_pass, run_end;
	logic [AW-1:0] final_k;
	assign k_last     = CW'({1'b0, k_q} + CW'(1)) == parts_q;
	assign i_last     = CW'(i_q + CW'(1)) == pl_q;
	assign final_pass = has_q[1];
	assign final_k    = has_q[1] ? lastk1_q : lastk0_q;
	assign run_end    = i_last && (pass_q == final_pass) && (k_q == final_k);

	assign stat.err_any    = err_q != 2'd0;
	assign stat.p_last     = CW'({1'b0, p_q} + CW'(1)) == count_q;
	assign stat.parts_zero = parts_q == '0;
	assign stat.kind_match = pt_rdata[PTW-1] == pass_q;
	assign stat.i_last     = i_last;
	assign stat.parts_done = k_last && pass_q;
	assign stat.slot_free  = !m_tvalid || m_tready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q <= 1'b0;
		end else if (cfg_we) begin
			hole_q <= cfg_wdata;
		end
	end

	// outline loading and clearing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			least_q <= {1'b0, {(CB-1){1'b1}}};
			start_q <= '0;
			err_q   <= 2'd0;
		end else if (cmd.clr) begin
			count_q <= '0;
			least_q <= {1'b0, {(CB-1){1'b1}}};
			start_q <= '0;
			err_q   <= 2'd0;
		end else if (cmd.load) begin
			if (room) begin
				count_q <= CW'(count_q + CW'(1));
				if (in_sx < least_q) begin
					least_q <= in_sx;
					start_q <= count_q[AW-1:0];
				end
				if (s_tuser) err_q <= err_q | STATUS_ARC;
			end else begin
				err_q <= STATUS_OVERFLOW;
			end
		end
	end

	// walk over the loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q     <= '0;
			dir_q   <= DIR_NONE;
			parts_q <= '0;
			has_q   <= 2'b00;
		end else if (cmd.walk_init) begin
			p_q     <= '0;
			dir_q   <= DIR_NONE;
			parts_q <= '0;
			has_q   <= 2'b00;
		end else begin
			if (cmd.walk_ev) begin
				p_q <= AW'(p_q + AW'(1));
				if (!run_cont) dir_q <= seg_dir;
			end
			if (pt_we) begin
				parts_q <= CW'(parts_q + CW'(1));
				has_q[part_kind_w] <= 1'b1;
			end
		end
	end

	// run offset, length and last part of each class
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			len_q <= '0;
			off_q <= '0;
		end else if (cmd.walk_ev) begin
			if (run_cont) begin
				len_q <= CW'(len_q + CW'(1));
			end else begin
				off_q <= p_q;
				len_q <= (seg_dir != DIR_NONE) ? CW'(1) : '0;
			end
		end
		if (pt_we) begin
			if (part_kind_w) lastk1_q <= parts_q[AW-1:0];
			else             lastk0_q <= parts_q[AW-1:0];
		end
	end

	// emission counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
			k_q    <= '0;
			i_q    <= '0;
		end else begin
			if (cmd.emit_init) begin
				pass_q <= 1'b0;
				k_q    <= '0;
			end else if (cmd.next_part) begin
				if (k_last) begin
					k_q    <= '0;
					pass_q <= 1'b1;
				end else begin
					k_q <= AW'(k_q + AW'(1));
				end
			end
			if (cmd.pt_ev) begin
				i_q <= '0;
			end else if (cmd.seg_ev) begin
				i_q <= CW'(i_q + CW'(1));
			end
		end
	end

	// current part fields
	always_ff @(posedge clk) begin
		if (cmd.pt_ev) begin
			po_q   <= pt_rdata[AW-1:0];
			pl_q   <= pt_rdata[AW+CW-1:AW];
			kind_q <= pt_rdata[PTW-1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.seg_ev || cmd.res_one) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seg_ev) begin
			if (rev) begin
				m_tdata <= {32'(r_sy), 32'(r_sx), 32'(r_ey), 32'(r_ex)};
			end else begin
				m_tdata <= {32'(r_ey), 32'(r_ex), 32'(r_sy), 32'(r_sx)};
			end
			m_tuser <= {STATUS_SEGMENT, i_last, kind_q};
			m_tlast <= run_end;
		end else if (cmd.res_one) begin
			m_tdata <= '0;
			m_tuser <= {(err_q != 2'd0) ? err_q : STATUS_NO_PARTS, 1'b0, 1'b0};
			m_tlast <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: design/polygon_x_monotone_chain_split.sv
// ----------------------------------------------------------------------------
// polygon_x_monotone_chain_split
// Splits one closed outline of straight segments into x-monotone parts.
// ----------------------------------------------------------------------------
// Segments are taken one per cycle and stored; the item with tlast closes the
// outline. The block then walks the loop from the first segment with the
// least start x, with one registered read of the segment store per segment,
// and emits the parts: each pass over the part table reads one entry per
// part, and each emitted segment takes one more read of the segment store
// and waits while the output register is still full. Falling runs come out
// first as supporting parts (kind 0), rising runs after them (kind 1);
// outline_is_hole swaps the classes, and the upper class comes out reversed.
// An arc, too many segments or an outline of only vertical segments gives a
// single status result. No new outline is taken until the last result of the
// current one has been handed to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_x_monotone_chain_split
	import pxmc_pkg::*;
#(
	parameter int unsigned MAX_SEGMENTS = PXMC_MAX_SEGMENTS,
	parameter int unsigned COORD_BITS   = PXMC_COORD_BITS
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire          cfg_wdata,   // outline_is_hole
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire [127:0]  s_tdata,     // seg_start_x, seg_start_y, seg_end_x, seg_end_y
	input  wire          s_tuser,     // is_arc
	input  wire          s_tlast,     // last_element
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [127:0] m_tdata,     // out_start_x, out_start_y, out_end_x, out_end_y
	output logic [3:0]   m_tuser,     // part_kind, part_last, result_status[1:0]
	output logic         m_tlast      // run_last
);

	cmd_t  cmd;
	stat_t stat;

	pxmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pxmc_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// a status result is always the only and final one, with zero coordinates
	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:2] != STATUS_SEGMENT) |-> m_tlast && (m_tdata == '0))
		else $error("status result not final or not zeroed");

	// the final segment result also closes its part
	a_last_closes_part: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && (m_tuser[3:2] == STATUS_SEGMENT) |-> m_tuser[1])
		else $error("final result does not close its part");

	// no new item is taken while an outline is still being emitted
	a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken during emission");

endmodule

`default_nettype wire
